### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Operation codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef struct packed {
		logic enq;
		logic deq;
		logic rej;
	} spq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} spq_stat_t;

endpackage

### sv/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: handshake controller
// Accepts one item, issues the matching command, holds the result until taken.
// ----------------------------------------------------------------------------
module spq_ctrl
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      op,
	output logic      out_valid,
	input  logic      out_stall,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_OUT  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign in_stall  = (state_q == S_OUT) && out_stall;
	assign out_valid = (state_q == S_OUT);
	assign accept    = in_valid && !in_stall;

	// drop an enqueue on a full row and a dequeue on an empty one as a reject
	assign cmd.enq = accept && (op == OP_ENQ) && !stat.full;
	assign cmd.deq = accept && (op == OP_DEQ) && !stat.empty;
	assign cmd.rej = accept && (((op == OP_ENQ) && stat.full) ||
		((op == OP_DEQ) && stat.empty));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_OUT;
			end
			S_OUT: begin
				// hold while stalled; stay when a new item replaces the taken one
				if (!out_stall && !accept) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath: sorted entry row with parallel compare and shift
// Each slot compares against the new priority and picks keep, insert or shift.
// ----------------------------------------------------------------------------
module spq_datapath
	import spq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 32,
	parameter int PRIO_WIDTH = 16,
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spq_cmd_t              cmd,
	input  logic [ELEM_WIDTH-1:0] elem_in,
	input  logic [PRIO_WIDTH-1:0] prio_in,
	output spq_stat_t             stat,
	output logic [ELEM_WIDTH-1:0] front_elem,
	output logic [PRIO_WIDTH-1:0] front_prio,
	output logic [CW-1:0]         count,
	output logic                  is_empty,
	output logic                  error
);

	logic [ELEM_WIDTH-1:0] elem_q [DEPTH];
	logic [PRIO_WIDTH-1:0] prio_q [DEPTH];
	logic [CW-1:0]         cnt_q;
	logic                  err_q;
	logic [DEPTH-1:0]      le;
	logic                  do_enq;
	logic                  do_deq;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_enq     = cmd.enq;
	assign do_deq     = cmd.deq;

	// slot stays put when it is valid and not above the new priority
	for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
		assign le[i] = (CW'(i) < cnt_q) && (prio_q[i] <= prio_in);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		logic le_prev;
		if (i == 0) begin : g_first
			assign le_prev = 1'b1;
		end else begin : g_rest
			assign le_prev = le[i-1];
		end

		always_ff @(posedge clk) begin
			if (do_enq && !le[i]) begin
				if (le_prev) begin
					elem_q[i] <= elem_in;
					prio_q[i] <= prio_in;
				end else if (i > 0) begin
					elem_q[i] <= elem_q[(i > 0) ? i - 1 : 0];
					prio_q[i] <= prio_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_deq && (i < DEPTH - 1)) begin
				elem_q[i] <= elem_q[(i < DEPTH - 1) ? i + 1 : i];
				prio_q[i] <= prio_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (do_enq) cnt_q <= cnt_q + CW'(1);
			else if (do_deq) cnt_q <= cnt_q - CW'(1);
			if (cmd.enq || cmd.deq || cmd.rej) err_q <= cmd.rej;
		end
	end

	assign front_elem = stat.empty ? '0 : elem_q[0];
	assign front_prio = stat.empty ? '0 : prio_q[0];
	assign count      = cnt_q;
	assign is_empty   = stat.empty;
	assign error      = err_q;

endmodule

### sv/sorted_priority_queue.sv
// Latency: a result is valid the cycle after its item is accepted.
// Throughput: one item per cycle unless the receiver stalls; a new item is
//   taken in the same cycle the previous result is taken.
// Reset: arst_n clears count, error flag and handshake state; the entry row
//   needs no clearing pass since only slots below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded minimum priority queue, sorted entry row
// Enqueue inserts after all entries of lower or equal priority; dequeue pops
// the front. Each item yields one result with front, count and error flag.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 32,
	parameter int PRIO_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [ELEM_WIDTH-1:0]        elem_in,
	input  logic [PRIO_WIDTH-1:0]        prio_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ELEM_WIDTH-1:0]        front_elem,
	output logic [PRIO_WIDTH-1:0]        front_prio,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         is_empty,
	output logic                         error
);

	localparam int CW = $clog2(DEPTH + 1);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	// controller: owns the handshakes, turns an accepted item into a command
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: entry row, count and error flag; outputs hold while stalled
	// because the row only changes on an accepted item
	spq_datapath #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH),
		.PRIO_WIDTH (PRIO_WIDTH),
		.CW         (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.elem_in    (elem_in),
		.prio_in    (prio_in),
		.stat       (stat),
		.front_elem (front_elem),
		.front_prio (front_prio),
		.count      (count),
		.is_empty   (is_empty),
		.error      (error)
	);

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted minimum priority queue
// Drives enqueue and dequeue items through the valid/stall handshake, predicts
// the front, count and error flag of every result from a local sorted row,
// and compares each result field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spq_pkg::*;

	localparam int QDEPTH = 16;

	// One result as the queue reports it after a step.
	typedef struct {
		logic [31:0] elem;
		logic [15:0] prio;
		logic [4:0]  cnt;
		logic        empty;
		logic        err;
	} front_report_t;

	// Clock, reset and every block input start at a known value.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        op        = OP_ENQ;
	logic [31:0] elem_in   = '0;
	logic [15:0] prio_in   = '0;
	logic        out_stall = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic [31:0] front_elem;
	logic [15:0] front_prio;
	logic [4:0]  count;
	logic        is_empty;
	logic        error;

	sorted_priority_queue #(
		.DEPTH(QDEPTH),
		.ELEM_WIDTH(32),
		.PRIO_WIDTH(16)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.elem_in(elem_in),
		.prio_in(prio_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.front_elem(front_elem),
		.front_prio(front_prio),
		.count(count),
		.is_empty(is_empty),
		.error(error)
	);

	always #1 clk = ~clk;

	// Shadow copy of the sorted entry row, slot 0 at the front.
	logic [31:0] row_elem [QDEPTH];
	logic [15:0] row_prio [QDEPTH];
	int          row_cnt = 0;

	// Reports still owed by the block, oldest first.
	front_report_t pending_reports[$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	int mismatches   = 0;
	int reports_seen = 0;
	int enq_done     = 0;
	int deq_done     = 0;
	int full_rejects = 0;
	int empty_rejects = 0;
	int peak_cnt     = 0;

	// Apply one step to the shadow row and return the report it causes.
	function automatic front_report_t advance_row(logic is_deq, logic [31:0] e,
			logic [15:0] p);
		front_report_t rep;
		int pos;
		rep.err = 1'b0;
		if (is_deq == OP_ENQ) begin
			if (row_cnt >= QDEPTH) begin
				rep.err = 1'b1;
				full_rejects++;
			end else begin
				// Insert after every entry of lower or equal priority.
				pos = 0;
				while (pos < row_cnt && row_prio[pos] <= p)
					pos++;
				for (int i = row_cnt; i > pos; i--) begin
					row_elem[i] = row_elem[i-1];
					row_prio[i] = row_prio[i-1];
				end
				row_elem[pos] = e;
				row_prio[pos] = p;
				row_cnt++;
				enq_done++;
			end
		end else begin
			if (row_cnt == 0) begin
				rep.err = 1'b1;
				empty_rejects++;
			end else begin
				for (int i = 0; i + 1 < row_cnt; i++) begin
					row_elem[i] = row_elem[i+1];
					row_prio[i] = row_prio[i+1];
				end
				row_cnt--;
				deq_done++;
			end
		end
		if (row_cnt > peak_cnt)
			peak_cnt = row_cnt;
		rep.elem  = (row_cnt > 0) ? row_elem[0] : 32'd0;
		rep.prio  = (row_cnt > 0) ? row_prio[0] : 16'd0;
		rep.cnt   = row_cnt[4:0];
		rep.empty = (row_cnt == 0);
		return rep;
	endfunction

	// Offer one item, holding it steady until it is taken, then predict.
	task automatic send_item(logic is_deq, logic [31:0] e, logic [15:0] p);
		// Idle the sender for a random number of cycles first.
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= is_deq;
		elem_in  <= e;
		prio_in  <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_reports.push_back(advance_row(is_deq, e, p));
	endtask

	// Hold the sender until every owed report has been taken.
	task automatic wait_all_reports();
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: stall at random with the current pressure.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < receiver_stall_pct);

	// Compare every taken result with the oldest prediction.
	always @(posedge clk) begin
		front_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: elem=%h prio=%h cnt=%0d empty=%b err=%b",
						$realtime, front_elem, front_prio, count, is_empty, error);
			end else begin
				want = pending_reports.pop_front();
				if (front_elem !== want.elem || front_prio !== want.prio ||
						count !== want.cnt || is_empty !== want.empty ||
						error !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: exp elem=%h prio=%h cnt=%0d empty=%b err=%b | got elem=%h prio=%h cnt=%0d empty=%b err=%b",
							$realtime, want.elem, want.prio, want.cnt, want.empty,
							want.err, front_elem, front_prio, count, is_empty, error);
				end
			end
		end
	end

	// Corners: empty pop, field extremes, equal priorities, full push.
	task automatic test_directed_corners();
		send_item(OP_DEQ, $urandom, 16'($urandom));   // pop on empty queue
		send_item(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_ENQ, 32'h0000_0000, 16'h0000);
		send_item(OP_ENQ, 32'h0000_0001, 16'h0000);   // ties keep arrival order
		send_item(OP_ENQ, 32'h0000_0002, 16'h8000);
		send_item(OP_ENQ, 32'h0000_0003, 16'h8000);
		send_item(OP_ENQ, 32'h0000_0004, 16'h8000);
		send_item(OP_ENQ, 32'h0000_0005, 16'hFFFF);
		for (int i = 0; i < QDEPTH - 7; i++)
			send_item(OP_ENQ, $urandom, 16'($urandom));
		send_item(OP_ENQ, 32'hDEAD_BEEF, 16'h0000);   // push on full queue
		for (int i = 0; i < 4; i++)
			send_item(OP_DEQ, $urandom, 16'($urandom));
	endtask

	// Random traffic in segments: each segment picks an enqueue bias and a
	// priority spread, so the queue swings between empty, full and ties.
	task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
		int left;
		int seg_len;
		int enq_pct;
		int prio_mode;
		logic [15:0] p;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		left = n_items;
		while (left > 0) begin
			seg_len = $urandom_range(60, 10);
			if (seg_len > left)
				seg_len = left;
			case ($urandom_range(2))
				0: enq_pct = 85;
				1: enq_pct = 50;
				default: enq_pct = 15;
			endcase
			prio_mode = $urandom_range(3);
			for (int i = 0; i < seg_len; i++) begin
				case (prio_mode)
					0: p = 16'($urandom_range(7));           // dense ties
					1: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					default: p = 16'($urandom);
				endcase
				send_item(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ,
					$urandom, p);
			end
			left -= seg_len;
		end
	endtask

	// Pause the sender until the block has answered everything, then resume.
	task automatic test_sender_pause();
		sender_idle_pct    = 0;
		receiver_stall_pct = 50;
		for (int i = 0; i < 6; i++)
			send_item(OP_ENQ, $urandom, 16'($urandom_range(3)));
		in_valid <= 1'b0;
		wait_all_reports();
		for (int i = 0; i < 6; i++)
			send_item(OP_DEQ, $urandom, 16'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_traffic(0, 0, 300);
		test_sender_pause();
		test_random_traffic(78, 0, 300);
		test_random_traffic(0, 78, 300);
		test_random_traffic(27, 27, 300);
		in_valid <= 1'b0;

		// Drain the owed reports, then give the block a few more cycles.
		wait_all_reports();
		receiver_stall_pct = 0;
		repeat (8) @(posedge clk);

		$display("Checked %0d results: %0d pushes, %0d pops, peak occupancy %0d.",
			reports_seen, enq_done, deq_done, peak_cnt);
		$display("Rejected %0d pushes on full and %0d pops on empty; %0d mismatches.",
			full_rejects, empty_rejects, mismatches);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: end a hung run well past the slowest correct one.
	initial begin
		#500000;
		$display("Timeout with %0d results still owed.", pending_reports.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
